// ----- rtl/xcfd_pkg.sv -----
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared constants and types for the sync-word frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int FRAME_WORDS = FRAME_BYTES / 2;
    localparam int SUM_WORDS   = FRAME_WORDS - 1;
    localparam int POS_W       = 5;
    localparam int LAST_POS    = FRAME_BYTES - 1;
    localparam int FIRST_DATA  = 2;

    localparam logic [15:0] SYNC_WORD_RESET = 16'hABCD;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;

    // frame as seen on the cycle its last byte arrives
    typedef struct packed {
        logic                          done;
        logic [FRAME_BYTES-1:0][7:0]   bytes;
    } frame_t;

    typedef struct packed {
        logic         ok;
        logic [15:0]  command_one;
        logic [15:0]  command_two;
        logic [15:0]  speed_right;
        logic [15:0]  speed_left;
        logic [15:0]  battery_voltage;
        logic [15:0]  board_temperature;
        logic [15:0]  led_command;
    } result_t;

endpackage

// ----- rtl/xcfd_if.sv -----
// ----------------------------------------------------------------------------
// xcfd interfaces
// Byte request channel and frame result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface xcfd_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfd_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] command_one;
    logic signed [15:0] command_two;
    logic signed [15:0] speed_right;
    logic signed [15:0] speed_left;
    logic signed [15:0] battery_voltage;
    logic signed [15:0] board_temperature;
    logic        [15:0] led_command;

    modport source (output valid, output command_one, output command_two,
                    output speed_right, output speed_left, output battery_voltage,
                    output board_temperature, output led_command, input ready);
    modport sink   (input valid, input command_one, input command_two,
                    input speed_right, input speed_left, input battery_voltage,
                    input board_temperature, input led_command, output ready);
endinterface

// ----- rtl/xcfd_collector.sv -----
// ----------------------------------------------------------------------------
// xcfd_collector
// Sync hunt, byte position counter and frame byte store.
// ----------------------------------------------------------------------------
module xcfd_collector (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  logic [15:0]          sync_word,
    output xcfd_pkg::frame_t     frame
);
    import xcfd_pkg::*;

    byte_t                 prev_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    byte_t                 store_reg [FRAME_BYTES];
    logic                  hit;
    logic                  collecting;

    assign hit        = (pos_reg == '0) && ({rx_byte, prev_reg} == sync_word);
    assign collecting = (pos_reg >= POS_W'(FIRST_DATA)) && (pos_reg <= POS_W'(LAST_POS));

    always_comb
    begin
        pos_next = pos_reg;
        if (hit)
        begin
            pos_next = POS_W'(FIRST_DATA);
        end
        else if (collecting)
        begin
            if (pos_reg == POS_W'(LAST_POS))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            prev_reg <= rx_byte;
            pos_reg  <= pos_next;
        end
    end

    // store has no reset: each entry is written before it is read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (hit)
            begin
                store_reg[0] <= prev_reg;
                store_reg[1] <= rx_byte;
            end
            for (int i = FIRST_DATA; i < FRAME_BYTES; i++)
            begin
                if (collecting && (pos_reg == POS_W'(i)))
                begin
                    store_reg[i] <= rx_byte;
                end
            end
        end
    end

    // last byte goes straight from the channel
    always_comb
    begin
        for (int i = 0; i < LAST_POS; i++)
        begin
            frame.bytes[i] = store_reg[i];
        end
        frame.bytes[LAST_POS] = rx_byte;
        frame.done            = accept && (pos_reg == POS_W'(LAST_POS));
    end

    a_pos_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != POS_W'(1)) && (pos_reg <= POS_W'(LAST_POS)))
        else $error("byte position out of range");

    a_hit_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && hit |=> pos_reg == POS_W'(FIRST_DATA))
        else $error("sync hit did not start a frame");

    a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
        frame.done |=> pos_reg == '0)
        else $error("frame end did not return to hunting");

endmodule

// ----- rtl/xcfd_checker.sv -----
// ----------------------------------------------------------------------------
// xcfd_checker
// XOR checksum and sync check over a complete frame, payload word split.
// ----------------------------------------------------------------------------
module xcfd_checker (
    input  xcfd_pkg::frame_t     frame,
    input  logic [15:0]          sync_word,
    output xcfd_pkg::result_t    result
);
    import xcfd_pkg::*;

    word_t words [FRAME_WORDS];
    word_t sum;

    always_comb
    begin
        for (int w = 0; w < FRAME_WORDS; w++)
        begin
            words[w] = {frame.bytes[2*w+1], frame.bytes[2*w]};
        end
        sum = '0;
        for (int w = 0; w < SUM_WORDS; w++)
        begin
            sum = sum ^ words[w];
        end
    end

    assign result.ok                = frame.done && (words[0] == sync_word)
                                      && (sum == words[SUM_WORDS]);
    assign result.command_one       = words[1];
    assign result.command_two       = words[2];
    assign result.speed_right       = words[3];
    assign result.speed_left        = words[4];
    assign result.battery_voltage   = words[5];
    assign result.board_temperature = words[6];
    assign result.led_command       = words[7];

endmodule

// ----- rtl/xor_checked_feedback_deframer.sv -----
// ----------------------------------------------------------------------------
// xor_checked_feedback_deframer
// Serial byte stream deframer with sync hunt and XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received byte per request. A byte is taken at every edge where
//         rx.valid and rx.ready are high.
//   res : one request per good frame carrying the seven payload words.
//   cfg_write / cfg_data : writes the 16-bit sync word (low byte first on
//         the wire). Write only while idle.
// Throughput: one byte per cycle while rx.ready is high. The sync compare, position counter and
//   the XOR tree over eight words all settle in the cycle the byte is taken.
// Output: the result request is valid in the cycle after the last (18th)
//   frame byte is taken; it sits in the output register.
// Stall: rx.ready stays high while the output register is empty or being
//   drained; with a result held and res.ready low, rx.ready drops so no
//   frame can be lost.
// Reset: sync word 0xABCD, previous byte zero, hunting for sync, output
//   register empty. Frame store is not cleared.
// Bad frames (checksum or sync mismatch) are dropped without a request.
// ----------------------------------------------------------------------------
module xor_checked_feedback_deframer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic [15:0]   cfg_data,
    xcfd_byte_if.sink     rx,
    xcfd_result_if.source res
);
    import xcfd_pkg::*;

    word_t     sync_reg;
    frame_t    frame;
    result_t   result;
    logic      accept;
    logic      load;
    logic      valid_reg;
    logic      valid_next;
    result_t   data_reg;

    // sync word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_WORD_RESET;
        end
        else if (cfg_write)
        begin
            sync_reg <= cfg_data;
        end
    end

    // take a byte whenever the output slot is free or emptying this cycle
    assign rx.ready = !valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;

    xcfd_collector u_collector (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .sync_word (sync_reg),
        .frame     (frame)
    );

    xcfd_checker u_checker (
        .frame     (frame),
        .sync_word (sync_reg),
        .result    (result)
    );

    assign load = result.ok;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holds no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign res.valid             = valid_reg;
    assign res.command_one       = $signed(data_reg.command_one);
    assign res.command_two       = $signed(data_reg.command_two);
    assign res.speed_right       = $signed(data_reg.speed_right);
    assign res.speed_left        = $signed(data_reg.speed_left);
    assign res.battery_voltage   = $signed(data_reg.battery_voltage);
    assign res.board_temperature = $signed(data_reg.board_temperature);
    assign res.led_command       = data_reg.led_command;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> rx.ready)
        else $error("input stalled with empty output slot");

    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(accept && frame.done))
        else $error("result without a completed frame");

    a_good_frame_shown: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("good frame not presented");

endmodule

// ----- dv/tb_xor_checked_feedback_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_xor_checked_feedback_deframer
// Self-checking bench for the sync-word deframer. Byte requests are fed
// through the rx channel while a local deframer model tracks the sync
// hunt, the 18-byte collection and the XOR check, queueing the payload of
// every good frame. Each result request is compared field by field with
// the oldest queued payload. Directed frames cover the payload extremes,
// bad checksums, sync patterns inside a frame, back-to-back frames and a
// sync word change in the middle of a frame; random phases then run
// mostly well-formed frames under several sync words, mixed with noise,
// corrupted and cut-off frames. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_xor_checked_feedback_deframer;

    import xcfd_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 3;
    // ~1550 bytes are sent with random gaps and output back-pressure;
    // keep a wide margin.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 18;
    // result shows in the cycle after the last byte; the rest is spare
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_BYTES = 1320;
    localparam int PHASE_BYTES  = 220;
    localparam int REPORT_MAX   = 10;

    // payload of one good frame, in wire order after the sync word
    typedef struct packed {
        logic signed [15:0] command_one;
        logic signed [15:0] command_two;
        logic signed [15:0] speed_right;
        logic signed [15:0] speed_left;
        logic signed [15:0] battery_voltage;
        logic signed [15:0] board_temperature;
        logic        [15:0] led_command;
    } telemetry_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [15:0] cfg_data;

    xcfd_byte_if   rx_if ();
    xcfd_result_if res_if ();

    xor_checked_feedback_deframer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .rx        (rx_if),
        .res       (res_if)
    );

    // ------------------------------------------------------------------
    // Deframer model state
    // ------------------------------------------------------------------
    word_t      model_sync;
    byte_t      hunt_prev;                  // byte of the previous request
    int         collect_pos;                // 0 = hunting, else next slot
    byte_t      collect_buf [FRAME_BYTES];
    telemetry_t pending_frames [$];         // payloads still owed by the DUT

    // staging area for the frame being sent
    byte_t      frame_buf [FRAME_BYTES];

    // run bookkeeping
    bit quiet;                              // no stalls on either side
    int bytes_sent;
    int frames_checked;
    int frames_dropped;
    int sync_writes;
    int mismatches;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    function automatic word_t collected_word(input int w);
        return {collect_buf[2*w+1], collect_buf[2*w]};
    endfunction

    // Advance the model by one accepted byte; queue a payload when a frame
    // completes with the current sync word in front and a matching XOR.
    function automatic void deframe_byte(input byte_t b);
        word_t      seen;
        word_t      sum;
        telemetry_t t;
        int         w;
        seen = {b, hunt_prev};
        // hunt only while no frame is open
        if (collect_pos == 0 && seen == model_sync)
        begin
            collect_buf[0] = hunt_prev;
            collect_buf[1] = b;
            collect_pos    = FIRST_DATA;
        end
        else if (collect_pos >= FIRST_DATA && collect_pos < FRAME_BYTES)
        begin
            collect_buf[collect_pos] = b;
            collect_pos++;
        end
        if (collect_pos == FRAME_BYTES)
        begin
            sum = '0;
            for (w = 0; w < SUM_WORDS; w++)
                sum ^= collected_word(w);
            // sync is rechecked here: it may have been rewritten mid-frame
            if (collected_word(0) == model_sync && sum == collected_word(SUM_WORDS))
            begin
                t.command_one       = collected_word(1);
                t.command_two       = collected_word(2);
                t.speed_right       = collected_word(3);
                t.speed_left        = collected_word(4);
                t.battery_voltage   = collected_word(5);
                t.board_temperature = collected_word(6);
                t.led_command       = collected_word(7);
                pending_frames.push_back(t);
            end
            else
                frames_dropped++;
            collect_pos = 0;
        end
        // kept across frames, so a frame tail can start the next sync
        hunt_prev = b;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Drive one byte request and wait for the handshake. valid is left
    // high on return; the next call or rx_quiesce decides it in this step.
    task automatic send_byte(input byte_t b);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= byte_t'($urandom);
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_span(input int first, input int last);
        int i;
        for (i = first; i <= last; i++)
            send_byte(frame_buf[i]);
    endtask

    // Stop sending, wait until every owed result has come out, then let
    // the output register settle.
    task automatic rx_quiesce();
        rx_if.valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only called with the block quiet (after rx_quiesce).
    task automatic write_sync(input word_t v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        model_sync = v;
        sync_writes++;
    endtask

    // Field values lean on the signed and unsigned edges.
    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic telemetry_t pick_telemetry();
        telemetry_t t;
        t.command_one       = pick_word();
        t.command_two       = pick_word();
        t.speed_right       = pick_word();
        t.speed_left        = pick_word();
        t.battery_voltage   = pick_word();
        t.board_temperature = pick_word();
        t.led_command       = pick_word();
        return t;
    endfunction

    function automatic word_t xor_without_led(input word_t sync, input telemetry_t t);
        return sync ^ t.command_one ^ t.command_two ^ t.speed_right ^ t.speed_left
               ^ t.battery_voltage ^ t.board_temperature;
    endfunction

    // Lay out a frame in frame_buf, optionally with one checksum bit flipped.
    function automatic void build_frame(input word_t sync, input telemetry_t t,
                                        input bit corrupt);
        word_t words [FRAME_WORDS];
        int    i;
        words[0] = sync;
        words[1] = t.command_one;
        words[2] = t.command_two;
        words[3] = t.speed_right;
        words[4] = t.speed_left;
        words[5] = t.battery_voltage;
        words[6] = t.board_temperature;
        words[7] = t.led_command;
        words[8] = xor_without_led(sync, t) ^ t.led_command;
        if (corrupt)
            words[8] ^= word_t'(1) << $urandom_range(0, 15);
        for (i = 0; i < FRAME_WORDS; i++)
        begin
            frame_buf[2*i]   = words[i][7:0];
            frame_buf[2*i+1] = words[i][15:8];
        end
    endfunction

    task automatic send_frame(input telemetry_t t, input bit corrupt);
        build_frame(model_sync, t, corrupt);
        send_span(0, LAST_POS);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the compare
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input word_t want,
                                          input word_t got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch on %s: expected %h, got %h (result %0d)",
                         name, want, got, frames_checked);
        end
    endfunction

    function automatic void check_telemetry();
        telemetry_t want;
        if (pending_frames.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("unexpected result request: cmd1 %h cmd2 %h led %h",
                         res_if.command_one, res_if.command_two, res_if.led_command);
            return;
        end
        want = pending_frames.pop_front();
        compare_field("command_one",       want.command_one,       res_if.command_one);
        compare_field("command_two",       want.command_two,       res_if.command_two);
        compare_field("speed_right",       want.speed_right,       res_if.speed_right);
        compare_field("speed_left",        want.speed_left,        res_if.speed_left);
        compare_field("battery_voltage",   want.battery_voltage,   res_if.battery_voltage);
        compare_field("board_temperature", want.board_temperature,
                      res_if.board_temperature);
        compare_field("led_command",       want.led_command,       res_if.led_command);
        frames_checked++;
    endfunction

    // Sampled at the edge, so values are the ones the handshake saw.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            check_telemetry();
        res_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still owed",
                 CYCLE_LIMIT, pending_frames.size());
        $display("tb_xor_checked_feedback_deframer failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Two good frames under the reset sync word, payload at the extremes.
    task automatic test_reset_sync_extremes();
        telemetry_t t;
        t = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF};
        send_frame(t, 1'b0);
        t = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFE, 16'h0001, 16'h0000};
        send_frame(t, 1'b0);
        rx_quiesce();
    endtask

    // Corrupt checksum is dropped and the hunt picks up the next frame.
    task automatic test_bad_checksum();
        send_frame(pick_telemetry(), 1'b1);
        send_frame(pick_telemetry(), 1'b0);
        rx_quiesce();
    endtask

    // Sync bytes inside the payload, both aligned and across a word
    // boundary, must be taken as plain data.
    task automatic test_sync_inside_frame();
        telemetry_t t;
        t = pick_telemetry();
        t.command_one       = model_sync;
        t.speed_right[15:8] = model_sync[7:0];
        t.speed_left[7:0]   = model_sync[15:8];
        send_frame(t, 1'b0);
        rx_quiesce();
    endtask

    // Good frame whose last byte is the sync low byte, then a frame sent
    // without its low sync byte: both must come out.
    task automatic test_back_to_back();
        telemetry_t t;
        word_t      partial;
        t = pick_telemetry();
        partial = xor_without_led(model_sync, t);
        t.led_command[15:8] = partial[15:8] ^ model_sync[7:0];
        send_frame(t, 1'b0);
        build_frame(model_sync, pick_telemetry(), 1'b0);
        send_span(1, LAST_POS);
        rx_quiesce();
    endtask

    // Half a frame, new sync word, rest of the frame: dropped. A frame
    // under the new word must then pass.
    task automatic test_sync_change_mid_frame();
        build_frame(model_sync, pick_telemetry(), 1'b0);
        send_span(0, 8);
        rx_quiesce();
        write_sync(~model_sync);
        send_span(9, LAST_POS);
        send_frame(pick_telemetry(), 1'b0);
        rx_quiesce();
    endtask

    // All-zero and all-one sync words.
    task automatic test_sync_extremes();
        write_sync(16'h0000);
        send_frame(pick_telemetry(), 1'b0);
        send_frame(pick_telemetry(), 1'b0);
        rx_quiesce();
        write_sync(16'hFFFF);
        send_frame(pick_telemetry(), 1'b0);
        send_frame(pick_telemetry(), 1'b0);
        rx_quiesce();
    endtask

    // Phases under different sync words; mostly good frames with random
    // content, plus noise, corrupted and cut-off frames. One phase runs
    // with no stalls at all.
    task automatic test_random_traffic();
        int target;
        int phase;
        int phase_end;
        int kind;
        int i;
        target = bytes_sent + RANDOM_BYTES;
        phase  = 0;
        while (bytes_sent < target)
        begin
            case (phase)
                0:       write_sync(16'h0000);
                1:       write_sync(16'hFFFF);
                2:       write_sync(SYNC_WORD_RESET);
                default: write_sync(word_t'($urandom));
            endcase
            quiet     = (phase == 2);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end && bytes_sent < target)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 70)
                    send_frame(pick_telemetry(), 1'b0);
                else if (kind < 80)
                    send_frame(pick_telemetry(), 1'b1);
                else if (kind < 88)
                begin
                    // line noise ahead of a good frame
                    for (i = $urandom_range(1, 5); i > 0; i--)
                        send_byte(byte_t'($urandom));
                    send_frame(pick_telemetry(), 1'b0);
                end
                else if (kind < 94)
                begin
                    // frame cut short; following bytes fill it up
                    build_frame(model_sync, pick_telemetry(), 1'b0);
                    send_span(0, $urandom_range(2, LAST_POS - 1));
                end
                else
                begin
                    build_frame(model_sync, pick_telemetry(), 1'b0);
                    // sync pattern straddling command words
                    frame_buf[3] = model_sync[7:0];
                    frame_buf[4] = model_sync[15:8];
                    build_frame(model_sync, '{{frame_buf[3], frame_buf[2]},
                        {frame_buf[5], frame_buf[4]}, pick_word(), pick_word(),
                        pick_word(), pick_word(), pick_word()}, 1'b0);
                    send_span(0, LAST_POS);
                end
            end
            // a cut-off frame may still be open here: the next sync write
            // then lands mid-frame
            rx_quiesce();
            phase++;
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_data      = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        quiet         = 1'b0;
        model_sync    = SYNC_WORD_RESET;
        hunt_prev     = '0;
        collect_pos   = 0;
        bytes_sent    = 0;
        frames_checked = 0;
        frames_dropped = 0;
        sync_writes   = 0;
        mismatches    = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_sync_extremes();
        test_bad_checksum();
        test_sync_inside_frame();
        test_back_to_back();
        test_sync_change_mid_frame();
        test_sync_extremes();
        test_random_traffic();

        rx_quiesce();

        $display("sent %0d byte requests under %0d sync word settings",
                 bytes_sent, sync_writes + 1);
        $display("checked %0d frame results, model dropped %0d frames, %0d mismatches",
                 frames_checked, frames_dropped, mismatches);
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("tb_xor_checked_feedback_deframer passed");
        else
            $display("tb_xor_checked_feedback_deframer failed");
        $finish;
    end

endmodule
